/* rtl/assert_macros.svh */
// Assertion macros shared by the gzip header parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define GZHP_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that is checked on every edge, reset included.
`define GZHP_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/gzhp_pkg.sv */
// Package with the word types, codes and constants of the gzip header parser.
package gzhp_pkg;

  // Parser phases.
  localparam logic [3:0] PH_ID1     = 4'd0;
  localparam logic [3:0] PH_ID2     = 4'd1;
  localparam logic [3:0] PH_CM      = 4'd2;
  localparam logic [3:0] PH_FLG     = 4'd3;
  localparam logic [3:0] PH_MTIME   = 4'd4;
  localparam logic [3:0] PH_XFL     = 4'd5;
  localparam logic [3:0] PH_OS      = 4'd6;
  localparam logic [3:0] PH_XLEN    = 4'd7;
  localparam logic [3:0] PH_EXTRA   = 4'd8;
  localparam logic [3:0] PH_NAME    = 4'd9;
  localparam logic [3:0] PH_COMMENT = 4'd10;
  localparam logic [3:0] PH_HCRC    = 4'd11;
  localparam logic [3:0] PH_DONE    = 4'd12;
  localparam logic [3:0] PH_ERR     = 4'd13;

  // Field tags reported with each byte.
  localparam logic [3:0] FID_MAGIC  = 4'd0;
  localparam logic [3:0] FID_AFTER  = 4'd11;

  // Error codes.
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_MAGIC  = 3'd1;
  localparam logic [2:0] ERR_METHOD = 3'd2;
  localparam logic [2:0] ERR_XFL    = 3'd3;
  localparam logic [2:0] ERR_OS     = 3'd4;
  localparam logic [2:0] ERR_CRC    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IGNORE_EXTRA   = 2'd0;
  localparam logic [1:0] CFG_IGNORE_NAME    = 2'd1;
  localparam logic [1:0] CFG_IGNORE_COMMENT = 2'd2;
  localparam logic [1:0] CFG_STRICT_MODE    = 2'd3;

  // FLG bit positions.
  localparam int FLG_HCRC    = 1;
  localparam int FLG_EXTRA   = 2;
  localparam int FLG_NAME    = 3;
  localparam int FLG_COMMENT = 4;

  // Header constants.
  localparam logic [7:0]  GZ_ID1    = 8'h1f;
  localparam logic [7:0]  GZ_ID2    = 8'h8b;
  localparam logic [7:0]  GZ_CM     = 8'h08;
  localparam logic [7:0]  OS_MAX    = 8'd13;
  localparam logic [7:0]  OS_UNKNOWN = 8'd255;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
    logic       restart;
  } src_word_t;

  typedef struct packed {
    logic [3:0]  field_id;
    logic [7:0]  data_out;
    logic        deliver;
    logic        header_done;
    logic        need_more;
    logic [2:0]  error_code;
    logic [4:0]  flag_bits;
    logic [31:0] mtime;
    logic [7:0]  xfl_byte;
    logic [7:0]  os_code;
    logic [15:0] extra_len;
  } res_word_t;

  typedef struct packed {
    logic ignore_extra;
    logic ignore_name;
    logic ignore_comment;
    logic strict_mode;
  } cfg_t;

endpackage

/* rtl/gzhp_crc.sv */
// One-byte update of the reflected CRC-32 used by the header check.
module gzhp_crc import gzhp_pkg::*; (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_byte,
  output logic [31:0] crc_out
);

  // Eight bit steps of the shift register, folded into one combinational update.
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_byte};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

/* rtl/gzhp_decode.sv */
// Header field decoder: member state registers and the per-byte next-state logic.
`include "assert_macros.svh"
module gzhp_decode import gzhp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      take,
  input  src_word_t word,
  output res_word_t res
);

  logic [3:0]  phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [31:0] running_crc, running_crc_next;
  logic [4:0]  flag_reg, flag_reg_next;
  logic [31:0] mtime_reg, mtime_reg_next;
  logic [7:0]  xfl_reg, xfl_reg_next;
  logic [7:0]  os_reg, os_reg_next;
  logic [15:0] xlen_reg, xlen_reg_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [2:0]  error_reg, error_reg_next;

  logic [3:0]  cur_phase;
  logic [15:0] cur_count;
  logic [31:0] cur_crc;
  logic [4:0]  cur_flags;
  logic [31:0] cur_mtime;
  logic [15:0] cur_xlen;
  logic [7:0]  cur_crc_low;
  logic [2:0]  cur_error;
  logic [7:0]  cur_xfl;
  logic [7:0]  cur_os;
  logic [31:0] crc_upd;
  logic [15:0] count_inc;
  logic [15:0] xlen_full;
  logic [3:0]  fid;
  logic [2:0]  fail;
  logic        deliver;

  // First optional field at or after the given phase that the flags call for.
  function automatic logic [3:0] next_stage(input logic [3:0] from, input logic [4:0] flags);
    logic [3:0] r;
    r = PH_DONE;
    if (from <= PH_HCRC && flags[FLG_HCRC]) r = PH_HCRC;
    if (from <= PH_COMMENT && flags[FLG_COMMENT]) r = PH_COMMENT;
    if (from <= PH_NAME && flags[FLG_NAME]) r = PH_NAME;
    if (from <= PH_XLEN && flags[FLG_EXTRA]) r = PH_XLEN;
    return r;
  endfunction

  // A restart byte sees cleared member state.
  always_comb begin
    if (word.restart) begin
      cur_phase   = PH_ID1;
      cur_count   = 16'd0;
      cur_crc     = CRC_INIT;
      cur_flags   = 5'd0;
      cur_mtime   = 32'd0;
      cur_xfl     = 8'd0;
      cur_os      = 8'd0;
      cur_xlen    = 16'd0;
      cur_crc_low = 8'd0;
      cur_error   = ERR_NONE;
    end else begin
      cur_phase   = phase;
      cur_count   = byte_count;
      cur_crc     = running_crc;
      cur_flags   = flag_reg;
      cur_mtime   = mtime_reg;
      cur_xfl     = xfl_reg;
      cur_os      = os_reg;
      cur_xlen    = xlen_reg;
      cur_crc_low = crc_low_byte;
      cur_error   = error_reg;
    end
  end

  gzhp_crc u_crc (
    .crc_in    (cur_crc),
    .data_byte (word.data_byte),
    .crc_out   (crc_upd)
  );

  assign count_inc = cur_count + 16'd1;
  assign xlen_full = {word.data_byte, cur_xlen[7:0]};

  // Field decode and phase transitions for one byte.
  always_comb begin
    phase_next        = cur_phase;
    byte_count_next   = cur_count;
    running_crc_next  = (cur_phase <= PH_COMMENT) ? crc_upd : cur_crc;
    flag_reg_next     = cur_flags;
    mtime_reg_next    = cur_mtime;
    xfl_reg_next      = cur_xfl;
    os_reg_next       = cur_os;
    xlen_reg_next     = cur_xlen;
    crc_low_byte_next = cur_crc_low;
    error_reg_next    = cur_error;
    fail              = ERR_NONE;
    deliver           = 1'b1;
    if (cur_phase == PH_ID1) fid = FID_MAGIC;
    else if (cur_phase <= PH_DONE) fid = cur_phase - 4'd1;
    else fid = FID_AFTER;

    case (cur_phase)
      PH_ID1: begin
        if (word.data_byte != GZ_ID1) fail = ERR_MAGIC;
        else phase_next = PH_ID2;
      end
      PH_ID2: begin
        if (word.data_byte != GZ_ID2) fail = ERR_MAGIC;
        else phase_next = PH_CM;
      end
      PH_CM: begin
        if (word.data_byte != GZ_CM) fail = ERR_METHOD;
        else phase_next = PH_FLG;
      end
      PH_FLG: begin
        flag_reg_next   = word.data_byte[4:0];
        phase_next      = PH_MTIME;
        byte_count_next = 16'd0;
      end
      PH_MTIME: begin
        case (cur_count[1:0])
          2'd0:    mtime_reg_next[7:0]   = cur_mtime[7:0] | word.data_byte;
          2'd1:    mtime_reg_next[15:8]  = cur_mtime[15:8] | word.data_byte;
          2'd2:    mtime_reg_next[23:16] = cur_mtime[23:16] | word.data_byte;
          default: mtime_reg_next[31:24] = cur_mtime[31:24] | word.data_byte;
        endcase
        byte_count_next = count_inc;
        if (count_inc >= 16'd4) begin
          phase_next      = PH_XFL;
          byte_count_next = 16'd0;
        end
      end
      PH_XFL: begin
        xfl_reg_next = word.data_byte;
        if (cfg.strict_mode && !(word.data_byte inside {8'd0, 8'd2, 8'd4})) fail = ERR_XFL;
        else phase_next = PH_OS;
      end
      PH_OS: begin
        os_reg_next = word.data_byte;
        if (cfg.strict_mode && !(word.data_byte inside {[8'd0:OS_MAX], OS_UNKNOWN})) begin
          fail = ERR_OS;
        end else begin
          phase_next      = next_stage(PH_XLEN, cur_flags);
          byte_count_next = 16'd0;
        end
      end
      PH_XLEN: begin
        deliver = !cfg.ignore_extra;
        if (cur_count == 16'd0) begin
          xlen_reg_next   = {8'd0, word.data_byte};
          byte_count_next = 16'd1;
        end else begin
          xlen_reg_next   = xlen_full;
          byte_count_next = 16'd0;
          phase_next      = (xlen_full == 16'd0) ? next_stage(PH_NAME, cur_flags) : PH_EXTRA;
        end
      end
      PH_EXTRA: begin
        deliver         = !cfg.ignore_extra;
        byte_count_next = count_inc;
        if (count_inc >= cur_xlen) begin
          phase_next      = next_stage(PH_NAME, cur_flags);
          byte_count_next = 16'd0;
        end
      end
      PH_NAME: begin
        deliver = !cfg.ignore_name;
        if (word.data_byte == 8'd0) phase_next = next_stage(PH_COMMENT, cur_flags);
      end
      PH_COMMENT: begin
        deliver = !cfg.ignore_comment;
        if (word.data_byte == 8'd0) phase_next = next_stage(PH_HCRC, cur_flags);
      end
      PH_HCRC: begin
        if (cur_count == 16'd0) begin
          crc_low_byte_next = word.data_byte;
          byte_count_next   = 16'd1;
        end else begin
          byte_count_next = 16'd0;
          if ({word.data_byte, cur_crc_low} != ~cur_crc[15:0]) fail = ERR_CRC;
          else phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        deliver = 1'b1;
      end
      default: begin
        deliver = 1'b0;
      end
    endcase

    // An error parks the parser until the next restart.
    if (fail != ERR_NONE) begin
      error_reg_next = fail;
      phase_next     = PH_ERR;
      deliver        = 1'b0;
    end

    res.field_id    = fid;
    res.data_out    = word.data_byte;
    res.deliver     = deliver;
    res.header_done = (fail == ERR_NONE) && (phase_next == PH_DONE) && (fid != FID_AFTER);
    res.need_more   = word.chunk_last && (phase_next != PH_DONE) && (phase_next != PH_ERR);
    res.error_code  = error_reg_next;
    res.flag_bits   = flag_reg_next;
    res.mtime       = mtime_reg_next;
    res.xfl_byte    = xfl_reg_next;
    res.os_code     = os_reg_next;
    res.extra_len   = xlen_reg_next;
  end

  // Member state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID1;
      byte_count   <= 16'd0;
      running_crc  <= CRC_INIT;
      flag_reg     <= 5'd0;
      mtime_reg    <= 32'd0;
      xfl_reg      <= 8'd0;
      os_reg       <= 8'd0;
      xlen_reg     <= 16'd0;
      crc_low_byte <= 8'd0;
      error_reg    <= ERR_NONE;
    end else if (take) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      running_crc  <= running_crc_next;
      flag_reg     <= flag_reg_next;
      mtime_reg    <= mtime_reg_next;
      xfl_reg      <= xfl_reg_next;
      os_reg       <= os_reg_next;
      xlen_reg     <= xlen_reg_next;
      crc_low_byte <= crc_low_byte_next;
      error_reg    <= error_reg_next;
    end
  end

  `GZHP_ASSERT_CLK(a_err_sticky, clk, rst,
    (take && !word.restart && phase == PH_ERR) |=> (phase == PH_ERR),
    "error phase left without restart")
  `GZHP_ASSERT_CLK(a_err_code, clk, rst,
    (phase == PH_ERR) |-> (error_reg != ERR_NONE),
    "error phase without an error code")
  `GZHP_ASSERT_CLK(a_done_phase, clk, rst,
    (take && res.header_done) |=> (phase == PH_DONE),
    "header done but parser not in done phase")

endmodule

/* rtl/gzhp_out_buf.sv */
// Result register with a skid stage, so the source side never waits on the sink combinationally.
`include "assert_macros.svh"
module gzhp_out_buf import gzhp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_take,
  input  res_word_t in_word,
  output logic      full,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res_word
);

  logic      skid_valid;
  res_word_t skid_word;
  logic      load_out;

  assign load_out = !res_valid || !res_stall;
  assign full     = skid_valid;

  // Control: output register first, skid only while the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      res_valid  <= skid_valid || in_take;
      skid_valid <= 1'b0;
    end else if (in_take) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload follows the same choices and needs no reset.
  always_ff @(posedge clk) begin
    if (load_out) begin
      res_word <= skid_valid ? skid_word : in_word;
    end else if (in_take) begin
      skid_word <= in_word;
    end
  end

  `GZHP_ASSERT_CLK(a_skid_behind_out, clk, rst, skid_valid |-> res_valid, "skid word held with empty output register")

endmodule

/* rtl/gzip_header_parser.sv */
// Top level of the gzip member header parser: configuration registers, decoder and result buffer.
//
//  channel  | handshake             | word
//  ---------+-----------------------+--------------------------------------------
//  src      | src_valid / src_stall | src_word: data_byte, chunk_last, restart
//  res      | res_valid / res_stall | res_word: field tag, byte, status, fields
//  cfg      | cfg_valid / cfg_ready | cfg_index (2 bits), cfg_data (1 bit)
//
// One byte is accepted every cycle while src_stall is low; its result is registered in the
// output or skid stage. The combinational path is the one-byte CRC-32 update plus field decode.
// Reset is synchronous and clears member state and configuration at once; no sweep.
// A stalled result moves into a skid stage, and src_stall rises only while that stage
// holds a word, so a byte is still taken in the cycle the sink first stalls.
module gzip_header_parser import gzhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  src_word_t  src_word,
  output logic       res_valid,
  input  logic       res_stall,
  output res_word_t  res_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  cfg_t      cfg;
  logic      take;
  logic      buf_full;
  res_word_t dec_word;

  assign cfg_ready = 1'b1;
  assign src_stall = buf_full;
  assign take      = src_valid && !buf_full;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IGNORE_EXTRA:   cfg.ignore_extra   <= cfg_data;
        CFG_IGNORE_NAME:    cfg.ignore_name    <= cfg_data;
        CFG_IGNORE_COMMENT: cfg.ignore_comment <= cfg_data;
        CFG_STRICT_MODE:    cfg.strict_mode    <= cfg_data;
        default:            cfg <= cfg;
      endcase
    end
  end

  gzhp_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .word (src_word),
    .res  (dec_word)
  );

  gzhp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_take   (take),
    .in_word   (dec_word),
    .full      (buf_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the gzip member header parser: directed rows, then random members.
module tb import gzhp_pkg::*; ;

  localparam int         STALL_LIMIT = 2000;
  localparam int         TAIL_CYCLES = 16;
  localparam logic [3:0] FID_METHOD  = 4'd1;
  // Row tail for bytes whose whole result comes from the parser model below.
  localparam logic [9:0] NO_CHECK    = 10'd0;

  // One stimulus byte, optionally with status fields that are known by hand.
  typedef struct packed {
    src_word_t  w;
    logic       typed;
    logic [3:0] fid;
    logic       dlv;
    logic       nm;
    logic [2:0] err;
  } byte_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  src_word_t src_word = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_word_t res_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = CFG_IGNORE_EXTRA;
  logic      cfg_data = 1'b0;

  // Both sides run without gaps while this is set.
  logic calm = 1'b0;

  // Parser model state and the configuration it runs under.
  cfg_t        cfg_now;
  logic [3:0]  st_phase;
  logic [15:0] st_count;
  logic [31:0] st_crc;
  logic [4:0]  st_flags;
  logic [31:0] st_mtime;
  logic [7:0]  st_xfl;
  logic [7:0]  st_os;
  logic [15:0] st_xlen;
  logic [7:0]  st_crc_lo;
  logic [2:0]  st_err;

  res_word_t parsed_q [$];
  res_word_t want;
  int        sent = 0;
  int        n_seen = 0;
  int        n_bad = 0;
  int        quiet_cycles = 0;

  // Hand-written rows: error codes, need_more, fields after an error, then one full header.
  byte_row_t dir_rows [0:21] = '{
    {8'h00, 1'b0, 1'b1, 1'b1, FID_MAGIC,  1'b0, 1'b0, ERR_MAGIC},
    {8'hff, 1'b1, 1'b0, 1'b1, FID_AFTER,  1'b0, 1'b0, ERR_MAGIC},
    {8'h1f, 1'b1, 1'b1, 1'b1, FID_MAGIC,  1'b1, 1'b1, ERR_NONE},
    {8'h8b, 1'b0, 1'b0, 1'b1, FID_MAGIC,  1'b1, 1'b0, ERR_NONE},
    {8'h07, 1'b1, 1'b0, 1'b1, FID_METHOD, 1'b0, 1'b0, ERR_METHOD},
    // All flags plus reserved bits, extreme MTIME and XFL, XLEN of zero,
    // empty name and comment, and a header CRC of zero.
    {8'h1f, 1'b0, 1'b1, NO_CHECK},
    {8'h8b, 1'b0, 1'b0, NO_CHECK},
    {8'h08, 1'b0, 1'b0, NO_CHECK},
    {8'hff, 1'b0, 1'b0, NO_CHECK},
    {8'hff, 1'b0, 1'b0, NO_CHECK},
    {8'hff, 1'b0, 1'b0, NO_CHECK},
    {8'hff, 1'b0, 1'b0, NO_CHECK},
    {8'hff, 1'b0, 1'b0, NO_CHECK},
    {8'hff, 1'b0, 1'b0, NO_CHECK},
    {8'h00, 1'b0, 1'b0, NO_CHECK},
    {8'h00, 1'b0, 1'b0, NO_CHECK},
    {8'h00, 1'b0, 1'b0, NO_CHECK},
    {8'h00, 1'b0, 1'b0, NO_CHECK},
    {8'h00, 1'b0, 1'b0, NO_CHECK},
    {8'h00, 1'b0, 1'b0, NO_CHECK},
    {8'h00, 1'b1, 1'b0, NO_CHECK},
    {8'h5a, 1'b0, 1'b0, NO_CHECK}
  };

  gzip_header_parser u_top (.*);

  always #4 clk = ~clk;

  // One byte step of the reflected CRC-32.
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_member();
    st_phase  = PH_ID1;
    st_count  = '0;
    st_crc    = CRC_INIT;
    st_flags  = '0;
    st_mtime  = '0;
    st_xfl    = '0;
    st_os     = '0;
    st_xlen   = '0;
    st_crc_lo = '0;
    st_err    = ERR_NONE;
  endfunction

  // First optional field at or after the given phase whose flag is set.
  function automatic logic [3:0] stage_from(logic [3:0] from);
    if (from <= PH_XLEN && st_flags[FLG_EXTRA]) return PH_XLEN;
    if (from <= PH_NAME && st_flags[FLG_NAME]) return PH_NAME;
    if (from <= PH_COMMENT && st_flags[FLG_COMMENT]) return PH_COMMENT;
    if (from <= PH_HCRC && st_flags[FLG_HCRC]) return PH_HCRC;
    return PH_DONE;
  endfunction

  // Advances the model by one byte and returns the word the parser should report.
  function automatic res_word_t parse_byte(src_word_t w);
    res_word_t  r;
    logic [7:0] b;
    logic [3:0] tag;
    logic [2:0] fail;
    logic       keep;
    b    = w.data_byte;
    fail = ERR_NONE;
    keep = 1'b1;
    if (w.restart) clear_member();
    tag = (st_phase == PH_ID1) ? FID_MAGIC :
          (st_phase <= PH_DONE) ? st_phase - 4'd1 : FID_AFTER;
    if (st_phase <= PH_COMMENT) st_crc = crc_step(st_crc, b);

    case (st_phase)
      PH_ID1: begin
        if (b != GZ_ID1) fail = ERR_MAGIC;
        else st_phase = PH_ID2;
      end
      PH_ID2: begin
        if (b != GZ_ID2) fail = ERR_MAGIC;
        else st_phase = PH_CM;
      end
      PH_CM: begin
        if (b != GZ_CM) fail = ERR_METHOD;
        else st_phase = PH_FLG;
      end
      PH_FLG: begin
        st_flags = b[4:0];
        st_phase = PH_MTIME;
        st_count = '0;
      end
      PH_MTIME: begin
        st_mtime = st_mtime | (32'(b) << (8 * st_count[1:0]));
        st_count = st_count + 16'd1;
        if (st_count >= 16'd4) begin
          st_phase = PH_XFL;
          st_count = '0;
        end
      end
      PH_XFL: begin
        st_xfl = b;
        if (cfg_now.strict_mode && !(b == 8'd0 || b == 8'd2 || b == 8'd4)) fail = ERR_XFL;
        else st_phase = PH_OS;
      end
      PH_OS: begin
        st_os = b;
        if (cfg_now.strict_mode && !(b <= OS_MAX || b == OS_UNKNOWN)) fail = ERR_OS;
        else begin
          st_phase = stage_from(PH_XLEN);
          st_count = '0;
        end
      end
      PH_XLEN: begin
        keep = !cfg_now.ignore_extra;
        if (st_count == 16'd0) begin
          st_xlen  = {8'd0, b};
          st_count = 16'd1;
        end else begin
          st_xlen  = {b, st_xlen[7:0]};
          st_count = '0;
          st_phase = (st_xlen == 16'd0) ? stage_from(PH_NAME) : PH_EXTRA;
        end
      end
      PH_EXTRA: begin
        keep = !cfg_now.ignore_extra;
        st_count = st_count + 16'd1;
        if (st_count >= st_xlen) begin
          st_phase = stage_from(PH_NAME);
          st_count = '0;
        end
      end
      PH_NAME: begin
        keep = !cfg_now.ignore_name;
        if (b == 8'd0) st_phase = stage_from(PH_COMMENT);
      end
      PH_COMMENT: begin
        keep = !cfg_now.ignore_comment;
        if (b == 8'd0) st_phase = stage_from(PH_HCRC);
      end
      PH_HCRC: begin
        if (st_count == 16'd0) begin
          st_crc_lo = b;
          st_count  = 16'd1;
        end else begin
          st_count = '0;
          if ({b, st_crc_lo} != ~st_crc[15:0]) fail = ERR_CRC;
          else st_phase = PH_DONE;
        end
      end
      PH_DONE: ;
      default: keep = 1'b0;
    endcase

    r.header_done = 1'b0;
    if (fail != ERR_NONE) begin
      st_err   = fail;
      st_phase = PH_ERR;
      keep     = 1'b0;
    end else if (st_phase == PH_DONE && tag != FID_AFTER) begin
      r.header_done = 1'b1;
    end

    r.field_id    = tag;
    r.data_out    = b;
    r.deliver     = keep;
    r.need_more   = w.chunk_last && st_phase != PH_DONE && st_phase != PH_ERR;
    r.error_code  = st_err;
    r.flag_bits   = st_flags;
    r.mtime       = st_mtime;
    r.xfl_byte    = st_xfl;
    r.os_code     = st_os;
    r.extra_len   = st_xlen;
    return r;
  endfunction

  task automatic note_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      if (n_bad < 10)
        $display("result %0d: %s expected %0h, got %0h", n_seen, name, e, a);
      n_bad++;
    end
  endtask

  // Offers one byte after a random gap, records its expected word and waits until taken.
  task automatic push_row(input byte_row_t row);
    res_word_t exp_word;
    while (!calm && $urandom_range(99) < 38) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word  <= row.w;
    exp_word = parse_byte(row.w);
    if (row.typed) begin
      exp_word.field_id   = row.fid;
      exp_word.deliver    = row.dlv;
      exp_word.need_more  = row.nm;
      exp_word.error_code = row.err;
    end
    parsed_q.push_back(exp_word);
    sent++;
    do @(posedge clk); while (src_stall);
  endtask

  // Stops sending and waits until every expected word has come back.
  task automatic settle();
    src_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Writes all four registers back to back.
  task automatic write_cfg(input cfg_t c);
    logic [1:0] idx [4];
    logic       vals [4];
    idx  = '{CFG_IGNORE_EXTRA, CFG_IGNORE_NAME, CFG_IGNORE_COMMENT, CFG_STRICT_MODE};
    vals = '{c.ignore_extra, c.ignore_name, c.ignore_comment, c.strict_mode};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cfg_now = c;
  endtask

  // Builds one member with random content and a correct header CRC most of the time.
  // A broken member gets one byte overwritten and is cut short.
  task automatic send_member(input bit whole);
    logic [7:0]  hdr [$];
    logic [7:0]  flg;
    logic [15:0] xl;
    logic [15:0] hc;
    logic [31:0] c;
    logic        is_last;
    int          n;
    flg = 8'($urandom_range(255));
    hdr = {GZ_ID1, GZ_ID2, GZ_CM, flg};
    repeat (4) hdr.push_back(8'($urandom_range(255)));
    hdr.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'(2 * $urandom_range(2)));
    hdr.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                  ($urandom_range(7) == 0) ? OS_UNKNOWN : 8'($urandom_range(13)));
    if (flg[FLG_EXTRA]) begin
      xl = ($urandom_range(29) == 0) ? 16'($urandom_range(300, 256)) : 16'($urandom_range(6));
      hdr.push_back(xl[7:0]);
      hdr.push_back(xl[15:8]);
      repeat (xl) hdr.push_back(8'($urandom_range(255)));
    end
    if (flg[FLG_NAME]) begin
      repeat ($urandom_range(5)) hdr.push_back(8'($urandom_range(255, 1)));
      hdr.push_back(8'h00);
    end
    if (flg[FLG_COMMENT]) begin
      repeat ($urandom_range(5)) hdr.push_back(8'($urandom_range(255, 1)));
      hdr.push_back(8'h00);
    end
    if (flg[FLG_HCRC]) begin
      c = CRC_INIT;
      foreach (hdr[i]) c = crc_step(c, hdr[i]);
      hc = ~c[15:0];
      if ($urandom_range(7) == 0) hc = hc ^ (16'd1 << $urandom_range(15));
      hdr.push_back(hc[7:0]);
      hdr.push_back(hc[15:8]);
    end
    repeat ($urandom_range(3)) hdr.push_back(8'($urandom_range(255)));
    if (!whole) begin
      n = $urandom_range(hdr.size() - 1);
      hdr[n] = 8'($urandom_range(255));
      n = $urandom_range(hdr.size() - 1, 1);
      while (hdr.size() > n) void'(hdr.pop_back());
    end
    foreach (hdr[i]) begin
      is_last = (i == hdr.size() - 1) || ($urandom_range(9) == 0);
      push_row({hdr[i], is_last, i == 0, NO_CHECK});
    end
  endtask

  // Result side: random stalls, and each accepted word is checked against the oldest one due.
  always @(posedge clk) begin
    res_stall <= (calm || rst) ? 1'b0 : ($urandom_range(99) < 38);
    if (!rst && res_valid && !res_stall) begin
      n_seen++;
      if (parsed_q.size() == 0) begin
        if (n_bad < 10) $display("result %0d: word with nothing pending", n_seen);
        n_bad++;
      end else begin
        want = parsed_q.pop_front();
        note_field("field_id",    32'(want.field_id),    32'(res_word.field_id));
        note_field("data_out",    32'(want.data_out),    32'(res_word.data_out));
        note_field("deliver",     32'(want.deliver),     32'(res_word.deliver));
        note_field("header_done", 32'(want.header_done), 32'(res_word.header_done));
        note_field("need_more",   32'(want.need_more),   32'(res_word.need_more));
        note_field("error_code",  32'(want.error_code),  32'(res_word.error_code));
        note_field("flag_bits",   32'(want.flag_bits),   32'(res_word.flag_bits));
        note_field("mtime",       want.mtime,            res_word.mtime);
        note_field("xfl_byte",    32'(want.xfl_byte),    32'(res_word.xfl_byte));
        note_field("os_code",     32'(want.os_code),     32'(res_word.os_code));
        note_field("extra_len",   32'(want.extra_len),   32'(res_word.extra_len));
      end
    end
  end

  // Watchdog: ends the run when no handshake completes for too long.
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed rows, then eight phases of random members.
  initial begin
    int   goal;
    int   pick;
    cfg_t cfg_next;
    cfg_now = '0;
    clear_member();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 22; i++) push_row(dir_rows[i]);

    for (int p = 0; p < 8; p++) begin
      settle();
      cfg_next = (p == 0) ? cfg_t'(4'h0) : (p == 1) ? cfg_t'(4'hf) :
                 cfg_t'(4'($urandom_range(15)));
      write_cfg(cfg_next);
      calm <= (p == 3);
      goal = sent + 80;
      while (sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          send_member(1'b1);
        end else if (pick < 92) begin
          send_member(1'b0);
        end else begin
          // Loose noise bytes with random restart and chunk marks.
          repeat ($urandom_range(8, 1))
            push_row({8'($urandom), $urandom_range(3) == 0, $urandom_range(3) == 0, NO_CHECK});
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
